@@ rtl/core/jsu_pkg.sv @@
// shared types, constants and helpers of the json string unescaper
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package jsu_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned OUT_LEN_W       = 16;
  localparam int unsigned MAX_RESULTS     = 3;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_TEXT = 7'b0000010,
    PH_ESC  = 7'b0000100,
    PH_HEX0 = 7'b0001000,
    PH_HEX1 = 7'b0010000,
    PH_HEX2 = 7'b0100000,
    PH_HEX3 = 7'b1000000
  } phase_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             data;
    logic [OUT_LEN_W-1:0]   len;
  } res_t;

  // {valid, value} of one ascii hex digit, either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsu_if.sv @@
// valid/ready channel interfaces for raw bytes in and decoded results out
// depends on jsu_pkg
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, in_byte, buffer_end, input ready);
  modport sink (input valid, in_byte, buffer_end, output ready);
endinterface

interface jsu_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    out_kind;
  logic [7:0]                    out_byte;
  logic [jsu_pkg::OUT_LEN_W-1:0] decoded_length;
  logic                          run_last;

  modport source (output valid, out_kind, out_byte, decoded_length, run_last, input ready);
  modport sink (input valid, out_kind, out_byte, decoded_length, run_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/json_string_unescape_utf8_top.sv @@
// json string unescaper with utf-8 encoding of \u escapes, top level
// depends on jsu_pkg and the channel interfaces in jsu_if.sv
// the first result of a byte is registered and shown in the cycle after the byte's transaction
// throughput: one raw byte per cycle while each byte gives at most one result and the output is ready;
//   a \u escape giving several utf-8 bytes holds the result buffer until the last of them leaves
// the three-entry result buffer drains one result a cycle while the output is ready; a new byte is taken
//   when the buffer is empty or its last entry leaves in the same cycle
// reset (asynchronous, active low): idle awaiting the opening quote, buffer empty
`default_nettype none

module json_string_unescape_utf8_top #(
  parameter int unsigned LengthBits = jsu_pkg::LENGTH_BITS_DEF
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  jsu_in_if.sink   in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};

  // decoder state
  phase_e                phase_q, phase_d;
  logic [11:0]           acc_q, acc_d;
  logic [LengthBits-1:0] len_q, len_d;

  // result buffer: slot 0 is the head shown at the output
  res_t       slot_q [MAX_RESULTS];
  res_t       res_new [MAX_RESULTS];
  logic [1:0] cnt_q;
  logic [1:0] n_new;

  logic       in_fire, out_fire;
  logic [7:0] c;
  logic       last;
  logic [4:0] hexd;
  logic [15:0] code;
  logic [LengthBits-1:0] len1, len2, len3;
  logic [7:0] esc_val;
  logic       esc_ok;

  // low 16 bits of the length counter, zero extended for narrow counters
  function automatic logic [OUT_LEN_W-1:0] len_field(input logic [LengthBits-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    return w[OUT_LEN_W-1:0];
  endfunction

  assign c    = in_i.in_byte;
  assign last = in_i.buffer_end;
  assign hexd = hex_digit(c);
  assign code = {acc_q, hexd[3:0]};

  // saturating counts after one, two and three data bytes
  assign len1 = (len_q == LenMax) ? len_q : len_q + 1'b1;
  assign len2 = (len1 == LenMax) ? len1 : len1 + 1'b1;
  assign len3 = (len2 == LenMax) ? len2 : len2 + 1'b1;

  // single-character escapes
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = c;
    unique case (c) inside
      CH_QUOTE, CH_SLASH, CH_BSLASH: esc_val = c;
      CH_B:    esc_val = BYTE_BS;
      CH_F:    esc_val = BYTE_FF;
      CH_N:    esc_val = BYTE_LF;
      CH_R:    esc_val = BYTE_CR;
      CH_T:    esc_val = BYTE_TAB;
      default: esc_ok  = 1'b0;
    endcase
  end

  // next state and the results caused by the byte on the input
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    len_d   = len_q;
    n_new   = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_new[i] = '{kind: KIND_DATA, data: 8'h00, len: '0};
    end
    unique case (phase_q)
      PH_IDLE: begin
        if (c != CH_QUOTE || last) begin
          // missing opening quote, or buffer gone right after it
          if (c == CH_QUOTE) begin
            len_d = '0;
          end
          res_new[0] = '{kind: KIND_ERR, data: 8'h00,
                         len: (c == CH_QUOTE) ? '0 : len_field(len_q)};
          n_new = 2'd1;
        end else begin
          len_d   = '0;
          phase_d = PH_TEXT;
        end
      end
      PH_TEXT: begin
        if (c == CH_QUOTE) begin
          phase_d    = PH_IDLE;
          res_new[0] = '{kind: KIND_END, data: 8'h00, len: len_field(len_q)};
          n_new      = 2'd1;
        end else if (last) begin
          phase_d    = PH_IDLE;
          acc_d      = '0;
          res_new[0] = '{kind: KIND_ERR, data: 8'h00, len: len_field(len_q)};
          n_new      = 2'd1;
        end else if (c == CH_BSLASH) begin
          phase_d = PH_ESC;
        end else begin
          len_d      = len1;
          res_new[0] = '{kind: KIND_DATA, data: c, len: len_field(len1)};
          n_new      = 2'd1;
        end
      end
      PH_ESC: begin
        if (last || (!esc_ok && c != CH_U)) begin
          phase_d    = PH_IDLE;
          acc_d      = '0;
          res_new[0] = '{kind: KIND_ERR, data: 8'h00, len: len_field(len_q)};
          n_new      = 2'd1;
        end else if (c == CH_U) begin
          acc_d   = '0;
          phase_d = PH_HEX0;
        end else begin
          phase_d    = PH_TEXT;
          len_d      = len1;
          res_new[0] = '{kind: KIND_DATA, data: esc_val, len: len_field(len1)};
          n_new      = 2'd1;
        end
      end
      PH_HEX0, PH_HEX1, PH_HEX2: begin
        if (!hexd[4] || last) begin
          phase_d    = PH_IDLE;
          acc_d      = '0;
          res_new[0] = '{kind: KIND_ERR, data: 8'h00, len: len_field(len_q)};
          n_new      = 2'd1;
        end else begin
          acc_d   = {acc_q[7:0], hexd[3:0]};
          phase_d = (phase_q == PH_HEX0) ? PH_HEX1 :
                    (phase_q == PH_HEX1) ? PH_HEX2 : PH_HEX3;
        end
      end
      PH_HEX3: begin
        acc_d = '0;
        if (!hexd[4] || last) begin
          phase_d    = PH_IDLE;
          res_new[0] = '{kind: KIND_ERR, data: 8'h00, len: len_field(len_q)};
          n_new      = 2'd1;
        end else begin
          phase_d = PH_TEXT;
          if (code < 16'h0080) begin
            len_d      = len1;
            res_new[0] = '{kind: KIND_DATA, data: code[7:0], len: len_field(len1)};
            n_new      = 2'd1;
          end else if (code < 16'h0800) begin
            // two-byte form: 110xxxxx 10xxxxxx
            len_d      = len2;
            res_new[0] = '{kind: KIND_DATA, data: {3'b110, code[10:6]},
                           len: len_field(len1)};
            res_new[1] = '{kind: KIND_DATA, data: {2'b10, code[5:0]},
                           len: len_field(len2)};
            n_new      = 2'd2;
          end else begin
            // three-byte form: 1110xxxx 10xxxxxx 10xxxxxx
            len_d      = len3;
            res_new[0] = '{kind: KIND_DATA, data: {4'b1110, code[15:12]},
                           len: len_field(len1)};
            res_new[1] = '{kind: KIND_DATA, data: {2'b10, code[11:6]},
                           len: len_field(len2)};
            res_new[2] = '{kind: KIND_DATA, data: {2'b10, code[5:0]},
                           len: len_field(len3)};
            n_new      = 2'd3;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        acc_d   = '0;
      end
    endcase
  end

  // accept while the buffer is empty or its last entry is leaving now
  assign in_i.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      len_q   <= '0;
      cnt_q   <= 2'd0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        len_q   <= len_d;
        cnt_q   <= n_new;
      end else if (out_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // payload slots: loaded whole on a transaction in, shifted down on one out
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        slot_q[i] <= res_new[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
    end
  end

  // the buffer only ever holds the results of one byte, so the final entry is its last
  assign out_o.valid          = (cnt_q != 2'd0);
  assign out_o.out_kind       = slot_q[0].kind;
  assign out_o.out_byte       = slot_q[0].data;
  assign out_o.decoded_length = slot_q[0].len;
  assign out_o.run_last       = (cnt_q == 2'd1);

endmodule

`default_nettype wire

@@ rtl/core/jsu_checker.sv @@
// port-level assertions for the json string unescaper, bound to its top level
// depends on jsu_pkg and json_string_unescape_utf8_top
`default_nettype none

module jsu_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          out_valid_i,
  input wire                          out_ready_i,
  input wire [1:0]                    out_kind_i,
  input wire [7:0]                    out_byte_i,
  input wire [jsu_pkg::OUT_LEN_W-1:0] decoded_length_i,
  input wire                          run_last_i
);
  import jsu_pkg::*;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_kind_i) && $stable(decoded_length_i) && $stable(run_last_i))
    else $error("result changed while stalled");

  // end and error results always close their run
  a_ctrl_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_DATA |-> run_last_i)
    else $error("end or error result not marked last");

  a_ctrl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_DATA |-> out_byte_i == 8'h00)
    else $error("end or error result with nonzero byte");

  // inside a multi-byte run the next byte follows at once with the count one up, or unchanged once saturated
  a_run_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_last_i |=> out_valid_i
      && out_kind_i == KIND_DATA
      && (decoded_length_i == $past(decoded_length_i) + 1'b1
          || decoded_length_i == $past(decoded_length_i)))
    else $error("broken utf-8 run");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.out_kind),
  .out_byte_i       (out_o.out_byte),
  .decoded_length_i (out_o.decoded_length),
  .run_last_i       (out_o.run_last)
);

`default_nettype wire

@@ dv/json_string_unescape_utf8_top_tb.sv @@
// self-checking testbench for json_string_unescape_utf8_top: raw string bytes in,
// decoded bytes, string ends and errors out, checked against a built-in predictor
// depends on jsu_pkg, the channel interfaces in jsu_if.sv and the top level
`timescale 1ns / 1ps

module json_string_unescape_utf8_top_tb;
  import jsu_pkg::*;

  // a narrow length counter, zero extended onto the 16-bit length field
  localparam int unsigned LEN_BITS          = 8;
  localparam int          RANDOM_ITEMS      = 90;
  localparam int          HOLD_CYCLES       = 64;
  localparam int          STALL_LIMIT       = 1000;
  localparam int          SETTLE_CYCLES     = 8;
  localparam int          MAX_REPORTS       = 10;

  // ascii ranges of hex digits
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  // utf-8 length thresholds of a 16-bit code unit
  localparam logic [15:0] UTF8_TWO_MIN   = 16'h0080;
  localparam logic [15:0] UTF8_THREE_MIN = 16'h0800;
  localparam logic [15:0] CP_EDGES [6] = '{16'h0000, 16'h007F, 16'h0080,
                                           16'h07FF, 16'h0800, 16'hFFFF};
  localparam logic [7:0]  ESC_LETTERS [8] = '{CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B,
                                              CH_F, CH_N, CH_R, CH_T};

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           data;
    logic [OUT_LEN_W-1:0] len;
    logic                 last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } raw_t;

  // value of an ascii hex digit, -1 when the byte is not one
  function automatic int hex_nibble(logic [7:0] c);
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return int'(c - CH_DIGIT0);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  class unescape_scoreboard;
    phase_e              phase;
    logic [11:0]         hex_acc;
    logic [LEN_BITS-1:0] decoded_count;
    decoded_t            pending_results[$];
    int mismatches, raw_bytes, results_seen, data_seen, ends_seen, errors_seen;

    function new();
      phase         = PH_IDLE;
      hex_acc       = '0;
      decoded_count = '0;
    endfunction

    function void expect_result(logic [1:0] k, logic [7:0] b);
      decoded_t r;
      r.kind = k;
      r.data = b;
      r.len  = OUT_LEN_W'(decoded_count);
      r.last = 1'b0;
      pending_results.push_back(r);
    endfunction

    function void expect_data(logic [7:0] b);
      if (decoded_count != '1) decoded_count++;
      expect_result(KIND_DATA, b);
    endfunction

    function void expect_error();
      phase   = PH_IDLE;
      hex_acc = '0;
      expect_result(KIND_ERR, 8'h00);
    endfunction

    // works out the results that one accepted raw byte causes
    function void note_raw_byte(logic [7:0] c, logic e);
      int          base;
      int          nib;
      logic [15:0] cp;
      base = pending_results.size();
      raw_bytes++;
      case (phase)
        PH_IDLE: begin
          if (c != CH_QUOTE || e) begin
            if (c == CH_QUOTE) decoded_count = '0;
            expect_error();
          end else begin
            decoded_count = '0;
            phase         = PH_TEXT;
          end
        end
        PH_TEXT: begin
          if (c == CH_QUOTE) begin
            phase = PH_IDLE;
            expect_result(KIND_END, 8'h00);
          end else if (e) begin
            expect_error();
          end else if (c == CH_BSLASH) begin
            phase = PH_ESC;
          end else begin
            expect_data(c);
          end
        end
        PH_ESC: begin
          if (e) begin
            expect_error();
          end else begin
            phase = PH_TEXT;
            case (c)
              CH_QUOTE, CH_SLASH, CH_BSLASH: expect_data(c);
              CH_B: expect_data(BYTE_BS);
              CH_F: expect_data(BYTE_FF);
              CH_N: expect_data(BYTE_LF);
              CH_R: expect_data(BYTE_CR);
              CH_T: expect_data(BYTE_TAB);
              CH_U: begin
                hex_acc = '0;
                phase   = PH_HEX0;
              end
              default: expect_error();
            endcase
          end
        end
        default: begin
          nib = hex_nibble(c);
          if (nib < 0 || e) begin
            expect_error();
          end else if (phase != PH_HEX3) begin
            hex_acc = {hex_acc[7:0], 4'(nib)};
            phase   = (phase == PH_HEX0) ? PH_HEX1 : (phase == PH_HEX1) ? PH_HEX2 : PH_HEX3;
          end else begin
            cp      = {hex_acc, 4'(nib)};
            hex_acc = '0;
            phase   = PH_TEXT;
            if (cp < UTF8_TWO_MIN) begin
              expect_data(cp[7:0]);
            end else if (cp < UTF8_THREE_MIN) begin
              expect_data({3'b110, cp[10:6]});
              expect_data({2'b10, cp[5:0]});
            end else begin
              expect_data({4'b1110, cp[15:12]});
              expect_data({2'b10, cp[11:6]});
              expect_data({2'b10, cp[5:0]});
            end
          end
        end
      endcase
      if (pending_results.size() > base)
        pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_decoded(decoded_t got);
      decoded_t want;
      results_seen++;
      if (got.kind == KIND_DATA) data_seen++;
      if (got.kind == KIND_END) ends_seen++;
      if (got.kind == KIND_ERR) errors_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d byte %02h len %0d last %0b",
                                got.kind, got.data, got.len, got.last));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.len !== want.len || got.last !== want.last)
        flag_mismatch($sformatf(
          "expected kind %0d byte %02h len %0d last %0b, got kind %0d byte %02h len %0d last %0b",
          want.kind, want.data, want.len, want.last,
          got.kind, got.data, got.len, got.last));
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    function void flag_leftovers();
      if (pending_results.size() != 0)
        flag_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_top #(
    .LengthBits(LEN_BITS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  unescape_scoreboard sb = new();

  raw_t raw_stream[$];   // bytes of the string being built, sent in one go
  int   bytes_sent;
  int   tx_steady, rx_steady;   // remaining items of a stretch with no idling
  bit   hold_off_req;
  int   hold_off_done;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // random per-item wait, now and then a stretch with none at all
  function automatic int draw_wait(ref int steady_left);
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) steady_left = $urandom_range(8, 30);
    return $urandom_range(0, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one raw byte per transaction; valid stays high when there is no gap
  // ---------------------------------------------------------------------------
  task automatic send_raw(input logic [7:0] b, input logic e);
    int gap;
    gap = draw_wait(tx_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.buffer_end <= e;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_raw_byte(b, e);
    bytes_sent++;
  endtask

  task automatic flush_stream();
    foreach (raw_stream[i]) send_raw(raw_stream[i].b, raw_stream[i].e);
    raw_stream.delete();
  endtask

  // ---------------------------------------------------------------------------
  // string builders
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b, logic e);
    raw_t r;
    r.b = b;
    r.e = e;
    raw_stream.push_back(r);
  endfunction

  // pushes a literal, buffer end optionally on its last byte
  function automatic void push_text(string s, bit end_on_last);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], end_on_last && (i == s.len() - 1));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_DIGIT0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 4'd10);
  endfunction

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 'h7F));
      1:       return 16'($urandom_range('h80, 'h7FF));
      2:       return 16'($urandom_range('h800, 'hFFFF));
      default: return CP_EDGES[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic void push_unicode(logic [15:0] cp);
    push_byte(CH_BSLASH, 1'b0);
    push_byte(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) push_byte(hex_char(cp[4*i +: 4]), 1'b0);
  endfunction

  function automatic void push_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    push_byte(b, 1'b0);
  endfunction

  function automatic bit is_escape_letter(logic [7:0] c);
    foreach (ESC_LETTERS[i]) if (c == ESC_LETTERS[i]) return 1'b1;
    return c == CH_U;
  endfunction

  // opening quote, a few pieces of content, no closing quote yet
  function automatic void push_open_string(int pieces);
    push_byte(CH_QUOTE, 1'b0);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: push_plain();
        5, 6: begin
          push_byte(CH_BSLASH, 1'b0);
          push_byte(ESC_LETTERS[$urandom_range(0, 7)], 1'b0);
        end
        default: push_unicode(pick_code_point());
      endcase
    end
  endfunction

  // one random string, mostly well formed, sometimes broken or preceded by junk
  task automatic send_random_string();
    logic [7:0] c;
    int         k;
    if ($urandom_range(0, 9) == 0) begin
      // junk while idle, possibly a quote that opens a string of its own
      repeat ($urandom_range(1, 3))
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    push_open_string($urandom_range(0, 8));
    case ($urandom_range(0, 9))
      0: begin
        // buffer runs out somewhere inside the string
        push_byte(CH_QUOTE, 1'b0);
        k = $urandom_range(0, raw_stream.size() - 1);
        raw_stream[k].e = 1'b1;
        while (raw_stream.size() > k + 1) void'(raw_stream.pop_back());
      end
      1: begin
        // escape letter that is not allowed
        do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c));
        push_byte(CH_BSLASH, 1'b0);
        push_byte(c, 1'b0);
      end
      2: begin
        // \u escape with a byte that is no hex digit
        push_byte(CH_BSLASH, 1'b0);
        push_byte(CH_U, 1'b0);
        repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
        push_byte(c, 1'b0);
      end
      default: push_byte(CH_QUOTE, 1'($urandom_range(0, 3) == 0));
    endcase
    flush_stream();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    decoded_t got;
    int       stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // block takes a byte only while its result buffer is empty, then stalls
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done += HOLD_CYCLES;
      end
      stall = draw_wait(rx_steady);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.kind = out_ch.out_kind;
      got.data = out_ch.out_byte;
      got.len  = out_ch.decoded_length;
      got.last = out_ch.run_last;
      sb.check_decoded(got);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no transaction happens for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int random_target;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = 8'h00;
    in_ch.buffer_end = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: missing opening quote, then a quote that is also the buffer end
    push_text("x", 1'b0);
    push_byte(CH_QUOTE, 1'b1);
    // byte extremes, buffer ending on the closing quote
    push_byte(CH_QUOTE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_QUOTE, 1'b1);
    // \u0000 gives a zero data byte, then the buffer ends inside the string
    push_text("\"\\u0000z", 1'b1);
    // mixed-case three-byte escape, then a bad escape letter
    push_text("\"\\uFfe8\\q", 1'b0);
    // bad hex digit
    push_text("\"\\u0g", 1'b0);
    flush_stream();

    // random strings
    random_target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < random_target) send_random_string();

    // long receiver hold-off while three-byte escapes keep arriving
    hold_off_req = 1'b1;
    push_byte(CH_QUOTE, 1'b0);
    repeat (8) push_unicode(16'($urandom_range('h800, 'hFFFF)));
    push_byte(CH_QUOTE, 1'b0);
    flush_stream();

    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flag_leftovers();

    $display("covered %0d raw bytes and %0d results: %0d data, %0d closed strings, %0d errors",
             sb.raw_bytes, sb.results_seen, sb.data_seen, sb.ends_seen, sb.errors_seen);
    $display("%0d cycles of output hold-off, %0d mismatches", hold_off_done, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/jsu_pkg.sv
rtl/core/jsu_if.sv
rtl/core/json_string_unescape_utf8_top.sv
rtl/core/jsu_checker.sv
dv/json_string_unescape_utf8_top_tb.sv
